// File: sv/dsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared widths, control struct and constant functions for the decimal
// seven-segment digit writer.
// ----------------------------------------------------------------------------
package dsd_pkg;

   localparam int VALUE_W   = 28;
   localparam int REST_W    = 27;
   localparam int POS_W     = 4;
   localparam int SEG_W     = 7;
   localparam int DIGIT_W   = 4;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int DEFAULT_DIGIT_COUNT = 8;

   localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
   localparam logic [SEG_W-1:0] SEG_MINUS = 7'h01;
   localparam logic [SEG_W-1:0] SEG_ONE   = 7'h30;

   localparam logic [VALUE_W-1:0] VALUE_BLANK = 28'hFFFFFFE;

   typedef struct packed {
      logic valid;
      logic blank;
      logic err;
      logic started;
   } dsd_ctl_type;

   function automatic logic [REST_W-1:0] pow10(input int n);
      logic [REST_W-1:0] p;
      p = REST_W'(1);
      for (int i = 0; i < n; i++) begin
         p = REST_W'(p * REST_W'(10));
      end
      return p;
   endfunction

   function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 7'h7E;
         4'd1:    s = 7'h30;
         4'd2:    s = 7'h6D;
         4'd3:    s = 7'h79;
         4'd4:    s = 7'h33;
         4'd5:    s = 7'h5B;
         4'd6:    s = 7'h5F;
         4'd7:    s = 7'h70;
         4'd8:    s = 7'h7F;
         default: s = 7'h7B;
      endcase
      return s;
   endfunction

endpackage

// File: sv/dsd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_cell
// One decimal position: extracts its digit from the remainder, writes the
// segment pattern into its slot and hands the rest to the next cell.
// ----------------------------------------------------------------------------
module dsd_cell #(
   parameter int DIGIT_COUNT = 8,
   parameter int POS         = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  dsd_pkg::dsd_ctl_type                   ctl_i,
   input  logic [dsd_pkg::REST_W-1:0]             rest_i,
   input  logic [DIGIT_COUNT*dsd_pkg::SEG_W-1:0]  segs_i,
   output dsd_pkg::dsd_ctl_type                   ctl_o,
   output logic [dsd_pkg::REST_W-1:0]             rest_o,
   output logic [DIGIT_COUNT*dsd_pkg::SEG_W-1:0]  segs_o
);
   import dsd_pkg::*;

   localparam logic [REST_W-1:0] PLACE = pow10(POS - 1);

   dsd_ctl_type                    ctl_ff, ctl_in;
   logic [REST_W-1:0]              rest_ff, rest_in;
   logic [DIGIT_COUNT*SEG_W-1:0]   segs_ff, segs_in;
   logic [DIGIT_W-1:0]             digit;
   logic [REST_W-1:0]              sub;
   logic [SEG_W-1:0]               seg;

   always_comb begin
      digit = '0;
      sub   = '0;
      for (int m = 1; m <= 9; m++) begin
         if (rest_i >= REST_W'(m * PLACE)) begin
            digit = DIGIT_W'(m);
            sub   = REST_W'(m * PLACE);
         end
      end
   end

   always_comb begin
      if (ctl_i.blank) begin
         seg = SEG_BLANK;
      end else if (ctl_i.err) begin
         if (POS == 2) begin
            seg = SEG_MINUS;
         end else if (POS == 1) begin
            seg = SEG_ONE;
         end else begin
            seg = SEG_BLANK;
         end
      end else if (!ctl_i.started && digit == '0) begin
         seg = SEG_BLANK;
      end else begin
         seg = seg_of(digit);
      end
   end

   always_comb begin
      ctl_in         = ctl_i;
      ctl_in.started = ctl_i.started | (digit != '0);
      rest_in        = rest_i - sub;
      segs_in        = segs_i;
      segs_in[(POS-1)*SEG_W +: SEG_W] = seg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rest_ff <= rest_in;
         segs_ff <= segs_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign rest_o = rest_ff;
   assign segs_o = segs_ff;

endmodule

// File: sv/dsd_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_serializer
// Holds one finished display word and emits its digit writes one per
// cycle while out_ready is high, leftmost position first.
// ----------------------------------------------------------------------------
module dsd_serializer #(
   parameter int DIGIT_COUNT = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic [DIGIT_COUNT*dsd_pkg::SEG_W-1:0]  in_segs,
   output logic                                   load,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [dsd_pkg::POS_W-1:0]              out_pos,
   output logic [dsd_pkg::SEG_W-1:0]              out_seg,
   output logic                                   out_last
);
   import dsd_pkg::*;

   localparam int SH_W = DIGIT_COUNT * SEG_W;

   logic              busy_ff, busy_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SH_W-1:0]   sh_ff, sh_in;
   logic              fire;

   assign fire     = busy_ff && out_ready;
   assign out_last = (pos_ff == POS_W'(1));
   assign load     = in_valid && (!busy_ff || (fire && out_last));

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      sh_in   = sh_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = POS_W'(DIGIT_COUNT);
         sh_in   = in_segs;
      end else if (fire) begin
         if (out_last) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff - POS_W'(1);
            sh_in  = sh_ff << SEG_W;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      sh_ff  <= sh_in;
   end

   assign out_valid = busy_ff;
   assign out_pos   = pos_ff;
   assign out_seg   = sh_ff[SH_W-1 -: SEG_W];

endmodule

// File: sv/decimal_seven_segment_digit_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_seven_segment_digit_writer
// Turns a display value into DIGIT_COUNT seven-segment digit writes.
// ----------------------------------------------------------------------------
// Each accepted value passes through a row of DIGIT_COUNT digit cells, one
// per decimal position, most significant first, then into an output
// serializer that emits DIGIT_COUNT writes, one per cycle while rsp_tready
// is high, from position DIGIT_COUNT down to 1 (tlast on position 1). The
// cell row takes a new value every cycle while it has room, so values queue
// behind the serializer; the sustained rate is set by the single write port
// of the serializer. -2 blanks all digits; -1, other negatives and values
// of 10^DIGIT_COUNT or more show minus on position 2 and '1' on position 1.
// Leading zeros are blank.
module decimal_seven_segment_digit_writer #(
   parameter int DIGIT_COUNT = dsd_pkg::DEFAULT_DIGIT_COUNT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dsd_pkg::REQ_DATA_W-1:0]   req_tdata,   // [27:0] value
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dsd_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [3:0] digit_position, [10:4] segments
   output logic                             rsp_tlast
);
   import dsd_pkg::*;

   localparam int SEGS_W = DIGIT_COUNT * SEG_W;
   localparam logic [REST_W-1:0] LIMIT = pow10(DIGIT_COUNT);

   dsd_ctl_type               ctl  [DIGIT_COUNT+1];
   logic [REST_W-1:0]         rest [DIGIT_COUNT+1];
   logic [SEGS_W-1:0]         segs [DIGIT_COUNT+1];
   logic [VALUE_W-1:0]        value;
   logic                      adv;
   logic                      load;
   logic [POS_W-1:0]          out_pos;
   logic [SEG_W-1:0]          out_seg;

   assign value = req_tdata[VALUE_W-1:0];

   always_comb begin
      ctl[0].valid   = req_tvalid;
      ctl[0].blank   = (value == VALUE_BLANK);
      ctl[0].err     = (value != VALUE_BLANK)
                       && (value[VALUE_W-1] || value[REST_W-1:0] >= LIMIT);
      ctl[0].started = 1'b0;
      rest[0]        = value[REST_W-1:0];
      segs[0]        = '0;
   end

   assign adv        = !ctl[DIGIT_COUNT].valid || load;
   assign req_tready = adv;

   for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
      dsd_cell #(
         .DIGIT_COUNT (DIGIT_COUNT),
         .POS         (DIGIT_COUNT - i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctl_i  (ctl[i]),
         .rest_i (rest[i]),
         .segs_i (segs[i]),
         .ctl_o  (ctl[i+1]),
         .rest_o (rest[i+1]),
         .segs_o (segs[i+1])
      );
   end

   dsd_serializer #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_ser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ctl[DIGIT_COUNT].valid),
      .in_segs   (segs[DIGIT_COUNT]),
      .load      (load),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pos   (out_pos),
      .out_seg   (out_seg),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, out_seg, out_pos};

`ifndef ASSERT_OFF
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("digit burst broken");

   a_pos_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast
      |=> rsp_tdata[3:0] == $past(rsp_tdata[3:0]) - 4'd1)
      else $error("digit position did not step down");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> ctl[DIGIT_COUNT].valid && rsp_tvalid)
      else $error("input stalled with free cell row");
`endif

endmodule

// File: dv/decimal_seven_segment_digit_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_seven_segment_digit_writer_test
// Self-checking bench for the decimal seven-segment digit writer.
// ----------------------------------------------------------------------------
// Streams display values into the block and checks every digit write against
// an in-bench prediction: position, segment pattern and tlast. A directed set
// covers zero, blank, error codes, the limit and the field extremes. A random
// set follows, mostly in-range values of random length plus error, blank and
// raw 28-bit noise. Both sides insert random gaps, with stretches of none.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [dsd_pkg::POS_W-1:0] position;
   logic [dsd_pkg::SEG_W-1:0] segments;
   logic                      last_write;
} digit_write_type;

typedef enum int {
   SHOW_DIGITS,
   SHOW_BLANK,
   SHOW_ERROR
} show_kind_type;

class digit_scoreboard;
   localparam int DIGITS      = dsd_pkg::DEFAULT_DIGIT_COUNT;
   localparam int VALUE_LIMIT = 100000000;
   localparam int BLANK_CODE  = -2;
   localparam logic [dsd_pkg::SEG_W-1:0] DIGIT_SEGS [10] = '{
      7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
   };

   digit_write_type pending_writes[$];
   int              failures;
   int              writes_checked;
   int              kind_count[3];

   function new();
      failures       = 0;
      writes_checked = 0;
      kind_count     = '{0, 0, 0};
   endfunction

   function void push_write(int pos, logic [dsd_pkg::SEG_W-1:0] seg);
      digit_write_type w;
      w.position   = dsd_pkg::POS_W'(pos);
      w.segments   = seg;
      w.last_write = (pos == 1);
      pending_writes.push_back(w);
   endfunction

   // expected digit writes for one accepted value
   function void note_value(logic [dsd_pkg::VALUE_W-1:0] value);
      int            val;
      int            rest;
      int            divisor;
      int            digit;
      bit            started;
      show_kind_type kind;
      val     = $signed(value);
      started = 0;
      if (val == BLANK_CODE) kind = SHOW_BLANK;
      else if (val < 0 || val >= VALUE_LIMIT) kind = SHOW_ERROR;
      else kind = SHOW_DIGITS;
      kind_count[kind]++;
      rest = val;
      for (int pos = DIGITS; pos >= 1; pos--) begin
         case (kind)
            SHOW_BLANK: begin
               push_write(pos, dsd_pkg::SEG_BLANK);
            end
            SHOW_ERROR: begin
               if (pos == 2) push_write(pos, dsd_pkg::SEG_MINUS);
               else if (pos == 1) push_write(pos, dsd_pkg::SEG_ONE);
               else push_write(pos, dsd_pkg::SEG_BLANK);
            end
            default: begin
               divisor = 1;
               for (int i = 1; i < pos; i++) divisor *= 10;
               digit = rest / divisor;
               rest  = rest % divisor;
               if (digit > 9) digit = 9;
               if (!started && digit == 0) begin
                  push_write(pos, dsd_pkg::SEG_BLANK);
               end else begin
                  started = 1;
                  push_write(pos, DIGIT_SEGS[digit]);
               end
            end
         endcase
      end
   endfunction

   function void check_write(logic [dsd_pkg::RSP_DATA_W-1:0] data, logic last);
      digit_write_type exp_w;
      logic [dsd_pkg::POS_W-1:0] got_pos;
      logic [dsd_pkg::SEG_W-1:0] got_seg;
      got_pos = data[dsd_pkg::POS_W-1:0];
      got_seg = data[dsd_pkg::POS_W +: dsd_pkg::SEG_W];
      if (pending_writes.size() == 0) begin
         failures++;
         $display("%0t: unexpected write: position %0d segments 'h%02h last %0b",
                  $time, got_pos, got_seg, last);
         return;
      end
      exp_w = pending_writes.pop_front();
      writes_checked++;
      if (got_pos !== exp_w.position) begin
         failures++;
         $display("%0t: position mismatch: expected %0d actual %0d",
                  $time, exp_w.position, got_pos);
      end
      if (got_seg !== exp_w.segments) begin
         failures++;
         $display("%0t: segments mismatch at position %0d: expected 'h%02h actual 'h%02h",
                  $time, exp_w.position, exp_w.segments, got_seg);
      end
      if (last !== exp_w.last_write) begin
         failures++;
         $display("%0t: tlast mismatch at position %0d: expected %0b actual %0b",
                  $time, exp_w.position, exp_w.last_write, last);
      end
   endfunction
endclass

module decimal_seven_segment_digit_writer_test;
   import dsd_pkg::*;

   localparam int RANDOM_VALUES = 187;
   localparam int MAX_GAP       = 6;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int TAIL_CYCLES   = 3 * (DEFAULT_DIGIT_COUNT + 1);
   localparam int VALUE_LIMIT   = 100000000;
   localparam int VALUE_MAX     = (1 << (VALUE_W - 1)) - 1;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   digit_scoreboard board;
   bit              no_gaps;
   int              values_sent;

   decimal_seven_segment_digit_writer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout with %0d writes outstanding", $time,
               board.pending_writes.size());
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   task automatic send_value(input logic [VALUE_W-1:0] value);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - VALUE_W){1'b0}}, value};
      do @(posedge clock); while (!req_tready);
      board.note_value(value);
      values_sent++;
   endtask

   function automatic logic [VALUE_W-1:0] random_value();
      int pick;
      int digits;
      int top;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         digits = $urandom_range(1, DEFAULT_DIGIT_COUNT);
         top = 1;
         for (int i = 0; i < digits; i++) top *= 10;
         return VALUE_W'($urandom_range(0, top - 1));
      end else if (pick < 66) begin
         return VALUE_W'(-1);
      end else if (pick < 72) begin
         return VALUE_BLANK;
      end else if (pick < 84) begin
         return VALUE_W'($urandom_range(VALUE_LIMIT, VALUE_MAX));
      end else begin
         return VALUE_W'($urandom());
      end
   endfunction

   // result side: random stall before each write
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         board.check_write(rsp_tdata, rsp_tlast);
      end
   end

   initial begin
      int directed_values[] = '{
         0, 1, 7, 9, 10, 1000, 10000000, 12345678, 80706050, 90909090,
         24681357, 55555555, 99999999, 100000000, 100000001, VALUE_MAX,
         -1, -2, -3, -(1 << (VALUE_W - 1)), 'h5555555, 'hAAAAAAA, 98765432
      };
      int waited;
      board       = new();
      no_gaps     = 1'b0;
      values_sent = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_values[i]) send_value(VALUE_W'(directed_values[i]));
      for (int n = 0; n < RANDOM_VALUES; n++) begin
         if (n % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         send_value(random_value());
      end
      req_tvalid <= 1'b0;
      no_gaps = 1'b0;

      waited = 0;
      while (board.pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.pending_writes.size() != 0) begin
         board.failures++;
         $display("%0t: %0d expected writes never arrived", $time,
                  board.pending_writes.size());
      end

      $display("Sent %0d values (%0d numeric, %0d blank, %0d error pattern).",
               values_sent, board.kind_count[SHOW_DIGITS],
               board.kind_count[SHOW_BLANK], board.kind_count[SHOW_ERROR]);
      $display("Checked %0d digit writes, %0d mismatches.",
               board.writes_checked, board.failures);
      if (board.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
